// ----- hdl/uf_pkg.sv -----
// ----------------------------------------------------------------------------
// uf_pkg
// Shared types and constants of the disjoint-set engine.
// ----------------------------------------------------------------------------
package uf_pkg;

	localparam int IDX_W     = 10;
	localparam int RANK_W    = 4;
	localparam int ACT_W     = 2;
	localparam int MAX_DEPTH = 1 << IDX_W;
	localparam int NUM_ELEMENTS_DEF = 1024;

	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

	localparam logic [ACT_W-1:0] ACT_MAKE  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FIND  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_UNION = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_COMPRESS,
		ST_LOAD_B,
		ST_MERGE,
		ST_DONE
	} state_t;

	// write requests to the parent and rank tables
	typedef struct packed {
		logic              pe;
		logic [IDX_W-1:0]  pa;
		logic [IDX_W-1:0]  pd;
		logic              re;
		logic [IDX_W-1:0]  ra;
		logic [RANK_W-1:0] rd;
	} tbl_wr_t;

	typedef struct packed {
		logic [IDX_W-1:0] root;
		logic             merged;
	} res_t;

endpackage

// ----- hdl/uf_tables.sv -----
// ----------------------------------------------------------------------------
// uf_tables
// Parent and rank tables: one write port each, a shared read address,
// registered read data.
// ----------------------------------------------------------------------------
module uf_tables #(
	parameter int NUM_ELEMENTS = uf_pkg::NUM_ELEMENTS_DEF
) (
	input  logic                        clk,
	input  uf_pkg::tbl_wr_t             wr,
	input  logic [uf_pkg::IDX_W-1:0]    rd_addr,
	output logic [uf_pkg::IDX_W-1:0]    rd_parent,
	output logic [uf_pkg::RANK_W-1:0]   rd_rank
);

	localparam int DEPTH = (NUM_ELEMENTS < uf_pkg::MAX_DEPTH) ? NUM_ELEMENTS
		: uf_pkg::MAX_DEPTH;
	localparam int AW = $clog2(DEPTH);

	logic [uf_pkg::IDX_W-1:0]  parent_mem [DEPTH];
	logic [uf_pkg::RANK_W-1:0] rank_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.pe) begin
			parent_mem[wr.pa[AW-1:0]] <= wr.pd;
		end
		rd_parent <= parent_mem[rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr.re) begin
			rank_mem[wr.ra[AW-1:0]] <= wr.rd;
		end
		rd_rank <= rank_mem[rd_addr[AW-1:0]];
	end

endmodule

// ----- hdl/uf_ctrl.sv -----
// ----------------------------------------------------------------------------
// uf_ctrl
// Sequencer: clearing pass, root walks, path compression and merge.
// ----------------------------------------------------------------------------
module uf_ctrl #(
	parameter int NUM_ELEMENTS = uf_pkg::NUM_ELEMENTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [uf_pkg::ACT_W-1:0]    in_action,
	input  logic [uf_pkg::IDX_W-1:0]    in_elem_a,
	input  logic [uf_pkg::IDX_W-1:0]    in_elem_b,
	output uf_pkg::tbl_wr_t             wr,
	output logic [uf_pkg::IDX_W-1:0]    rd_addr,
	input  logic [uf_pkg::IDX_W-1:0]    rd_parent,
	input  logic [uf_pkg::RANK_W-1:0]   rd_rank,
	output logic                        res_valid,
	input  logic                        res_ready,
	output uf_pkg::res_t                res
);

	localparam int DEPTH = (NUM_ELEMENTS < uf_pkg::MAX_DEPTH) ? NUM_ELEMENTS
		: uf_pkg::MAX_DEPTH;
	localparam logic [uf_pkg::IDX_W-1:0] LAST = uf_pkg::IDX_W'(DEPTH - 1);
	localparam logic [16:0] N_L = 17'(NUM_ELEMENTS);

	uf_pkg::state_t state_q, state_d;
	logic [uf_pkg::IDX_W-1:0]  clr_q, clr_d;

	logic [uf_pkg::IDX_W-1:0]  cur_q, cur_d;
	logic [uf_pkg::IDX_W-1:0]  start_q, start_d;
	logic [uf_pkg::IDX_W-1:0]  top_q, top_d;
	logic [uf_pkg::RANK_W-1:0] rkt_q, rkt_d;
	logic [uf_pkg::IDX_W-1:0]  ra_q, ra_d;
	logic [uf_pkg::RANK_W-1:0] rka_q, rka_d;
	logic [uf_pkg::IDX_W-1:0]  eb_q, eb_d;
	logic                      union_q, union_d;
	logic                      second_q, second_d;
	uf_pkg::res_t              res_q, res_d;

	logic                      fin;
	logic [uf_pkg::IDX_W-1:0]  f_root;
	logic [uf_pkg::RANK_W-1:0] f_rank;
	logic                      oor;

	assign oor = ({7'd0, in_elem_a} >= N_L) ||
		((in_action == uf_pkg::ACT_UNION) && ({7'd0, in_elem_b} >= N_L));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uf_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q    <= cur_d;
		start_q  <= start_d;
		top_q    <= top_d;
		rkt_q    <= rkt_d;
		ra_q     <= ra_d;
		rka_q    <= rka_d;
		eb_q     <= eb_d;
		union_q  <= union_d;
		second_q <= second_d;
		res_q    <= res_d;
	end

	always_comb begin
		state_d  = state_q;
		clr_d    = clr_q;
		cur_d    = cur_q;
		start_d  = start_q;
		top_d    = top_q;
		rkt_d    = rkt_q;
		ra_d     = ra_q;
		rka_d    = rka_q;
		eb_d     = eb_q;
		union_d  = union_q;
		second_d = second_q;
		res_d    = res_q;
		wr       = '0;
		rd_addr  = cur_q;
		in_ready = 1'b0;
		res_valid = 1'b0;
		fin      = 1'b0;
		f_root   = top_q;
		f_rank   = rkt_q;

		case (state_q)
			uf_pkg::ST_CLEAR: begin
				wr.pe = 1'b1;
				wr.pa = clr_q;
				wr.pd = clr_q;
				wr.re = 1'b1;
				wr.ra = clr_q;
				wr.rd = '0;
				if (clr_q == LAST) begin
					state_d = uf_pkg::ST_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			uf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = in_elem_a;
				if (in_valid) begin
					res_d.merged = 1'b0;
					res_d.root   = in_elem_a;
					if (in_action != uf_pkg::ACT_MAKE && in_action != uf_pkg::ACT_FIND &&
						in_action != uf_pkg::ACT_UNION) begin
						res_d.root = '0;
						state_d    = uf_pkg::ST_DONE;
					end else if (oor) begin
						state_d = uf_pkg::ST_DONE;
					end else if (in_action == uf_pkg::ACT_MAKE) begin
						wr.pe = 1'b1;
						wr.pa = in_elem_a;
						wr.pd = in_elem_a;
						wr.re = 1'b1;
						wr.ra = in_elem_a;
						wr.rd = '0;
						state_d = uf_pkg::ST_DONE;
					end else begin
						cur_d    = in_elem_a;
						start_d  = in_elem_a;
						eb_d     = in_elem_b;
						union_d  = (in_action == uf_pkg::ACT_UNION);
						second_d = 1'b0;
						state_d  = uf_pkg::ST_WALK;
					end
				end
			end
			uf_pkg::ST_WALK: begin
				if (rd_parent == cur_q) begin
					if (start_q == cur_q) begin
						fin    = 1'b1;
						f_root = cur_q;
						f_rank = rd_rank;
					end else begin
						top_d   = cur_q;
						rkt_d   = rd_rank;
						rd_addr = start_q;
						cur_d   = start_q;
						state_d = uf_pkg::ST_COMPRESS;
					end
				end else begin
					rd_addr = rd_parent;
					cur_d   = rd_parent;
				end
			end
			uf_pkg::ST_COMPRESS: begin
				// cur_q is never the root here, and the read goes one link ahead
				wr.pe = 1'b1;
				wr.pa = cur_q;
				wr.pd = top_q;
				if (rd_parent == top_q) begin
					fin = 1'b1;
				end else begin
					rd_addr = rd_parent;
					cur_d   = rd_parent;
				end
			end
			uf_pkg::ST_LOAD_B: begin
				// gap state so the last compression write has landed before eb is read
				rd_addr  = eb_q;
				cur_d    = eb_q;
				start_d  = eb_q;
				second_d = 1'b1;
				state_d  = uf_pkg::ST_WALK;
			end
			uf_pkg::ST_MERGE: begin
				state_d = uf_pkg::ST_DONE;
				if (ra_q == top_q) begin
					res_d.root   = ra_q;
					res_d.merged = 1'b0;
				end else if (rka_q < rkt_q) begin
					wr.pe = 1'b1;
					wr.pa = ra_q;
					wr.pd = top_q;
					res_d.root   = top_q;
					res_d.merged = 1'b1;
				end else begin
					wr.pe = 1'b1;
					wr.pa = top_q;
					wr.pd = ra_q;
					if (rka_q == rkt_q && rka_q != uf_pkg::RANK_MAX) begin
						wr.re = 1'b1;
						wr.ra = ra_q;
						wr.rd = uf_pkg::RANK_W'(rka_q + 1'b1);
					end
					res_d.root   = ra_q;
					res_d.merged = 1'b1;
				end
			end
			uf_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = uf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = uf_pkg::ST_IDLE;
			end
		endcase

		if (fin) begin
			top_d = f_root;
			rkt_d = f_rank;
			if (!union_q) begin
				res_d.root   = f_root;
				res_d.merged = 1'b0;
				state_d      = uf_pkg::ST_DONE;
			end else if (!second_q) begin
				ra_d    = f_root;
				rka_d   = f_rank;
				state_d = uf_pkg::ST_LOAD_B;
			end else begin
				state_d = uf_pkg::ST_MERGE;
			end
		end
	end

	assign res = res_q;

endmodule

// ----- hdl/uf_out.sv -----
// ----------------------------------------------------------------------------
// uf_out
// Output register between the sequencer and the result stream.
// ----------------------------------------------------------------------------
module uf_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_valid,
	output logic                 res_ready,
	input  uf_pkg::res_t         res,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata
);

	logic         vld_q;
	uf_pkg::res_t out_q;

	assign res_ready = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (res_ready) begin
			vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {5'd0, out_q.merged, out_q.root};

endmodule

// ----- hdl/union_find_rank_path_compression.sv -----
// ----------------------------------------------------------------------------
// union_find_rank_path_compression
// Disjoint-set engine with union by rank and path compression.
// ----------------------------------------------------------------------------
// Each operation is taken one at a time and produces one result transfer.
// Make set and rejected operations go straight to the result. Find walks
// from the element to its root and then makes a compression pass that
// repoints each link on the path at the root; both go through the single
// read port of the parent/rank tables, which has registered read data.
// Union runs two finds plus a gap and a merge step; under union by rank the
// path depth stays near log2 of the element count. After reset a clearing
// pass over min(NUM_ELEMENTS, 1024) entries initialises the tables; s_tready
// stays low until it ends. A result waiting in the output register does not
// hold off the next operation.
// ----------------------------------------------------------------------------
module union_find_rank_path_compression #(
	parameter int NUM_ELEMENTS = uf_pkg::NUM_ELEMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [9:0] elem_a, [19:10] elem_b, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [9:0] root, [10] merged, rest zero
);

	uf_pkg::tbl_wr_t                wr;
	logic [uf_pkg::IDX_W-1:0]       rd_addr;
	logic [uf_pkg::IDX_W-1:0]       rd_parent;
	logic [uf_pkg::RANK_W-1:0]      rd_rank;
	logic                           res_valid;
	logic                           res_ready;
	uf_pkg::res_t                   res;

	uf_tables #(
		.NUM_ELEMENTS(NUM_ELEMENTS)
	) u_tables (
		.clk      (clk),
		.wr       (wr),
		.rd_addr  (rd_addr),
		.rd_parent(rd_parent),
		.rd_rank  (rd_rank)
	);

	uf_ctrl #(
		.NUM_ELEMENTS(NUM_ELEMENTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_action(s_tuser),
		.in_elem_a(s_tdata[9:0]),
		.in_elem_b(s_tdata[19:10]),
		.wr       (wr),
		.rd_addr  (rd_addr),
		.rd_parent(rd_parent),
		.rd_rank  (rd_rank),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	uf_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- sim/uf_checker.sv -----
// ----------------------------------------------------------------------------
// uf_checker
// Predicts every operation on the disjoint-set engine from its own parent and
// rank tables and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module uf_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // [9:0] elem_a, [19:10] elem_b, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] action
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [9:0] root, [10] merged, rest zero
	output int          mismatches,
	output int          outstanding,
	output int          results_seen,
	output int          merges_seen
);
	import uf_pkg::*;

	localparam int N = NUM_ELEMENTS_DEF;

	logic [IDX_W-1:0]  parent_of [N];
	logic [RANK_W-1:0] rank_of   [N];
	res_t              pending_results [$];

	int errs;
	int seen;
	int merges;

	// walk to the root, then repoint the whole path at it
	function automatic logic [IDX_W-1:0] find_root(input logic [IDX_W-1:0] start);
		logic [IDX_W-1:0] top;
		logic [IDX_W-1:0] walk;
		logic [IDX_W-1:0] nxt;
		int               steps;
		top   = start;
		steps = 0;
		while (parent_of[top] != top && steps < N) begin
			top = parent_of[top];
			steps++;
		end
		walk  = start;
		steps = 0;
		while (walk != top && steps < N) begin
			nxt             = parent_of[walk];
			parent_of[walk] = top;
			walk            = nxt;
			steps++;
		end
		return top;
	endfunction

	// indexes are 10 bits wide and the table holds 1024 entries, so no
	// operation can name an element out of range here
	function automatic res_t apply_op(input logic [ACT_W-1:0] act,
			input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
		res_t             r;
		logic [IDX_W-1:0] ra;
		logic [IDX_W-1:0] rb;
		r.root   = '0;
		r.merged = 1'b0;
		case (act)
			ACT_MAKE: begin
				parent_of[a] = a;
				rank_of[a]   = '0;
				r.root       = a;
			end
			ACT_FIND: begin
				r.root = find_root(a);
			end
			ACT_UNION: begin
				ra = find_root(a);
				rb = find_root(b);
				if (ra == rb) begin
					r.root = ra;
				end else if (rank_of[ra] < rank_of[rb]) begin
					parent_of[ra] = rb;
					r.root        = rb;
					r.merged      = 1'b1;
				end else begin
					parent_of[rb] = ra;
					if (rank_of[ra] == rank_of[rb] && rank_of[ra] != RANK_MAX)
						rank_of[ra] = rank_of[ra] + 1'b1;
					r.root   = ra;
					r.merged = 1'b1;
				end
			end
			default: ;  // unknown action: state untouched, zero result
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				parent_of[i] = i[IDX_W-1:0];
				rank_of[i]   = '0;
			end
			pending_results.delete();
			errs   = 0;
			seen   = 0;
			merges = 0;
		end else begin
			// a result is registered, so it can never belong to the item
			// accepted at this same edge
			if (s_tvalid && s_tready)
				pending_results.push_back(apply_op(s_tuser, s_tdata[IDX_W-1:0],
					s_tdata[2*IDX_W-1:IDX_W]));
			if (m_tvalid && m_tready) begin
				seen++;
				if (pending_results.size() == 0) begin
					$error("result transfer with no operation pending: root=%0d merged=%0d",
						m_tdata[IDX_W-1:0], m_tdata[IDX_W]);
					errs++;
				end else begin
					exp_r = pending_results.pop_front();
					if (exp_r.merged)
						merges++;
					if (m_tdata[IDX_W-1:0] !== exp_r.root) begin
						$error("root: expected %0d, got %0d", exp_r.root, m_tdata[IDX_W-1:0]);
						errs++;
					end
					if (m_tdata[IDX_W] !== exp_r.merged) begin
						$error("merged: expected %0d, got %0d", exp_r.merged, m_tdata[IDX_W]);
						errs++;
					end
					if (m_tdata[15:IDX_W+1] !== '0) begin
						$error("tdata padding: expected 0, got %0h", m_tdata[15:IDX_W+1]);
						errs++;
					end
				end
			end
		end
		mismatches   <= errs;
		outstanding  <= pending_results.size();
		results_seen <= seen;
		merges_seen  <= merges;
	end

endmodule

// ----- sim/union_find_rank_path_compression_tb.sv -----
// ----------------------------------------------------------------------------
// union_find_rank_path_compression_tb
// Drives make-set, find, union and unknown actions into the disjoint-set
// engine: a directed opening, then random trees built by rank and random
// operations over shifting element windows, random gaps on both streams and
// one long output stall. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module union_find_rank_path_compression_tb;
	import uf_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

	localparam int RANDOM_OPS  = 1250;
	localparam int HOLD_AFTER  = 300;    // results before the long output stall
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN       = 60;
	localparam int WATCHDOG_NS = 7_200_000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	int mismatches;
	int outstanding;
	int results_seen;
	int merges_seen;

	int ops_sent;
	int ops_by_action [4];
	int results_rx;
	bit quiet_tx;
	bit quiet_rx;
	bit held;

	logic [IDX_W-1:0] win_base;
	int               win_size;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	union_find_rank_path_compression dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	uf_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.merges_seen  (merges_seen)
	);

	// returns at the edge of the input transfer; valid stays high into the
	// next call when that one draws no gap
	task automatic send_op(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		int gap;
		if (ops_sent % 64 == 0)
			quiet_tx = ($urandom_range(0, 3) == 0);
		gap = quiet_tx ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {4'b0, b, a};
		do @(posedge clk); while (!s_tready);
		ops_sent++;
		ops_by_action[act]++;
	endtask

	function automatic logic [IDX_W-1:0] pick_elem();
		if ($urandom_range(0, 6) == 0)
			return IDX_W'($urandom);
		return win_base + IDX_W'($urandom_range(0, win_size - 1));
	endfunction

	// fresh singletons merged pairwise, so every round meets equal ranks
	task automatic build_tree(input logic [IDX_W-1:0] base, input int depth);
		int n;
		n = 1 << depth;
		for (int i = 0; i < n; i++)
			send_op(ACT_MAKE, base + IDX_W'(i), IDX_W'($urandom));
		for (int stride = 1; stride < n; stride *= 2) begin
			for (int i = 0; i < n; i += 2 * stride) begin
				if ($urandom_range(0, 1))
					send_op(ACT_UNION, base + IDX_W'(i), base + IDX_W'(i + stride));
				else
					send_op(ACT_UNION, base + IDX_W'(i + stride), base + IDX_W'(i));
			end
		end
		for (int i = 0; i < n / 2; i++)
			send_op(ACT_FIND, base + IDX_W'($urandom_range(0, n - 1)), IDX_W'($urandom));
	endtask

	task automatic random_op();
		logic [ACT_W-1:0] act;
		int               pick;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			act = ACT_UNKNOWN;
		else if (pick < 15)
			act = ACT_MAKE;
		else if (pick < 50)
			act = ACT_FIND;
		else
			act = ACT_UNION;
		send_op(act, pick_elem(), pick_elem());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// extremes, every action, and the corner behaviours
		send_op(ACT_MAKE, 10'd0, 10'd1023);
		send_op(ACT_MAKE, 10'd1023, 10'd0);
		send_op(ACT_FIND, 10'd0, 10'd0);
		send_op(ACT_FIND, 10'd1023, 10'd1023);
		send_op(ACT_UNION, 10'd0, 10'd1023);
		send_op(ACT_UNION, 10'd1023, 10'd0);        // already one set
		send_op(ACT_UNION, 10'd5, 10'd5);           // set with itself
		send_op(ACT_UNION, 10'd1, 10'd2);
		send_op(ACT_UNION, 10'd3, 10'd4);
		send_op(ACT_UNION, 10'd1, 10'd3);           // equal ranks, first root kept
		send_op(ACT_UNION, 10'd6, 10'd4);           // lower rank hangs under
		send_op(ACT_FIND, 10'd4, 10'd0);            // path 4 -> 1, already compressed by the union above
		send_op(ACT_UNION, 10'd7, 10'd8);
		send_op(ACT_UNION, 10'd8, 10'd2);
		send_op(ACT_MAKE, 10'd3, 10'd0);            // element inside a larger set
		send_op(ACT_FIND, 10'd3, 10'd0);
		send_op(ACT_FIND, 10'd2, 10'd0);
		send_op(ACT_UNKNOWN, 10'd1023, 10'd1023);
		send_op(ACT_UNKNOWN, 10'd512, 10'd341);
		send_op(ACT_UNION, 10'd682, 10'd341);
		send_op(ACT_FIND, 10'd341, 10'd682);

		win_base = IDX_W'($urandom);
		win_size = 64;
		while (ops_sent < 21 + RANDOM_OPS) begin
			if ($urandom_range(0, 99) < 4) begin
				win_base = IDX_W'($urandom);
				win_size = ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(8, 64);
			end
			if ($urandom_range(0, 9) < 2)
				build_tree(IDX_W'($urandom), $urandom_range(2, 5));
			else
				random_op();
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN) @(posedge clk);

		$display("%0d operations issued (make %0d, find %0d, union %0d, unknown %0d)",
			ops_sent, ops_by_action[ACT_MAKE], ops_by_action[ACT_FIND],
			ops_by_action[ACT_UNION], ops_by_action[ACT_UNKNOWN]);
		$display("%0d results checked, %0d of them merges", results_seen, merges_seen);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// output side: random stalls, quiet stretches, one long hold-off
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (results_rx % 64 == 0)
				quiet_rx = ($urandom_range(0, 3) == 0);
			if (results_rx == HOLD_AFTER && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = quiet_rx ? 0 : $urandom_range(0, 10);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_rx++;
		end
	end

	initial begin
		#(WATCHDOG_NS);
		$display("timeout: %0d operations sent, %0d results received", ops_sent, results_rx);
		$display("Test completed with failures");
		$finish;
	end

endmodule
